// ----- sv/key_autorepeat_scheduler_defines.svh -----
// Assertion macros shared by the scheduler RTL.
`ifndef KEY_AUTOREPEAT_SCHEDULER_DEFINES_SVH
`define KEY_AUTOREPEAT_SCHEDULER_DEFINES_SVH

// Same-cycle implication, checked on every rising clk edge outside reset.
`define KAS_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("scheduler check failed");

// Next-cycle implication, checked on every rising clk edge outside reset.
`define KAS_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("scheduler sequencing check failed");

`endif

// ----- sv/kas_pkg.sv -----
`timescale 1ns / 1ps
package kas_pkg;

  localparam int SLOTS       = 8;
  localparam int MAX_RESULTS = 8;
  localparam int KEY_W       = 32;
  localparam int TIME_W      = 48;
  localparam int DELAY_W     = 16;
  localparam int CNT_W       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int NRES_W      = $clog2(MAX_RESULTS + 1);

  localparam logic [DELAY_W-1:0] DELAY_RESET    = DELAY_W'(400);
  localparam logic [DELAY_W-1:0] INTERVAL_RESET = DELAY_W'(50);

  // Configuration register indexes
  typedef enum logic [0:0] {
    REG_INITIAL_DELAY   = 1'b0,
    REG_REPEAT_INTERVAL = 1'b1
  } reg_idx_t;

  typedef enum logic [1:0] {
    CMD_START = 2'd0,
    CMD_STOP  = 2'd1,
    CMD_TICK  = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    KIND_ACK    = 2'd0,
    KIND_REPEAT = 2'd1,
    KIND_IDLE   = 2'd2
  } kind_t;

  typedef struct packed {
    cmd_t              cmd;
    logic [KEY_W-1:0]  key_id;
    logic [TIME_W-1:0] now;
  } in_t;

  typedef struct packed {
    kind_t             kind;
    logic              ok;
    logic [KEY_W-1:0]  key_id_res;
    logic [TIME_W-1:0] stamp;
    logic              last;
  } out_t;

  // One table slot, the content of one cell of the ring
  typedef struct packed {
    logic              active;
    logic [KEY_W-1:0]  key;
    logic [TIME_W-1:0] due;
  } slot_t;

  // Verdict of the head unit on the slot it is looking at
  typedef struct packed {
    slot_t slot;  // slot value written back to the ring tail
    logic  hit;   // tick: slot is due and fires a repeat
    logic  fin;   // start: search ends at this slot
    logic  ok;    // start: key was placed in this slot
  } head_res_t;

  // Time plus delay, saturating at the top of the time range
  function automatic logic [TIME_W-1:0] add_sat(input logic [TIME_W-1:0] t,
                                                 input logic [DELAY_W-1:0] d);
    logic [TIME_W:0] s;
    s = {1'b0, t} + {{(TIME_W + 1 - DELAY_W){1'b0}}, d};
    return s[TIME_W] ? {TIME_W{1'b1}} : s[TIME_W-1:0];
  endfunction

endpackage

// ----- sv/key_autorepeat_scheduler.sv -----
`timescale 1ns / 1ps
// Typematic repeat scheduler. The held-key table lives in a ring of SLOTS
// cells that rotates one place per cycle during a walk, unless a due slot waits
// for a full output; each item walks the whole ring once through a single head
// unit, and a new item is accepted only once the last one's final result is in
// the output register. A tick gives one repeat item per due slot in slot order
// (at most MAX_RESULTS), or one idle item when nothing is due; start and stop
// give one acknowledge. A repeat item waits in a one-deep hold until the next
// due slot or the end of the walk shows whether it is the last one.
module key_autorepeat_scheduler (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  kas_pkg::in_t                 in_data,
  output logic                         out_valid,
  input  logic                         out_stall,
  output kas_pkg::out_t                out_data,
  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  kas_pkg::reg_idx_t            cfg_index,
  input  logic [kas_pkg::DELAY_W-1:0]  cfg_data
);
  import kas_pkg::*;
  `include "key_autorepeat_scheduler_defines.svh"

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_t;

  state_t             state;
  logic [CNT_W-1:0]   cnt;
  logic [NRES_W-1:0]  nres;
  logic               done;
  logic               start_ok;
  logic               pend_valid;
  logic [KEY_W-1:0]   pend_key;
  in_t                cur;
  logic [DELAY_W-1:0] delay;
  logic [DELAY_W-1:0] interval;

  slot_t     cell_out [SLOTS];
  head_res_t res;
  logic      out_free;
  logic      advance;
  logic      emit;
  out_t      emit_data;
  logic      scan_end;

  // Ring of slot cells; the tail takes the head unit's write-back
  for (genvar i = 0; i < SLOTS; i++) begin : g_cell
    slot_t cin;
    if (i == SLOTS - 1) begin : g_tail
      assign cin = res.slot;
    end else begin : g_mid
      assign cin = cell_out[i+1];
    end
    kas_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .shift    (advance),
      .slot_in  (cin),
      .slot_out (cell_out[i])
    );
  end

  kas_head u_head (
    .head     (cell_out[0]),
    .cmd      (cur.cmd),
    .key      (cur.key_id),
    .now      (cur.now),
    .delay    (delay),
    .interval (interval),
    .done     (done),
    .room     (nres < NRES_W'(MAX_RESULTS)),
    .res      (res)
  );

  assign in_stall  = (state != ST_IDLE);
  assign cfg_ready = 1'b1;
  assign out_free  = !out_valid || !out_stall;
  assign scan_end  = (cnt == CNT_W'(SLOTS - 1));

  // Hold the ring while a due slot needs the output and the output is full
  assign advance = (state == ST_SCAN) && !(res.hit && pend_valid && !out_free);

  // Pick the item to load into the output register
  always_comb begin
    emit      = 1'b0;
    emit_data = '0;
    unique case (state)
      ST_SCAN: begin
        if (res.hit && pend_valid && out_free) begin
          emit                 = 1'b1;
          emit_data.kind       = KIND_REPEAT;
          emit_data.ok         = 1'b1;
          emit_data.key_id_res = pend_key;
          emit_data.stamp      = cur.now;
        end
      end
      ST_DONE: begin
        emit           = out_free;
        emit_data.last = 1'b1;
        case (cur.cmd)
          CMD_START: begin
            emit_data.kind = KIND_ACK;
            emit_data.ok   = start_ok;
          end
          CMD_STOP: begin
            emit_data.kind = KIND_ACK;
            emit_data.ok   = 1'b1;
          end
          CMD_TICK: begin
            emit_data.ok    = 1'b1;
            emit_data.stamp = cur.now;
            if (pend_valid) begin
              emit_data.kind       = KIND_REPEAT;
              emit_data.key_id_res = pend_key;
            end else begin
              emit_data.kind = KIND_IDLE;
            end
          end
          default: begin
            emit_data.kind = KIND_ACK;
            emit_data.ok   = 1'b0;
          end
        endcase
      end
      default: begin
        emit = 1'b0;
      end
    endcase
  end

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      delay    <= DELAY_RESET;
      interval <= INTERVAL_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_INITIAL_DELAY:   delay    <= cfg_data;
        REG_REPEAT_INTERVAL: interval <= cfg_data;
        default:             delay    <= delay;
      endcase
    end
  end

  // Sequence one item through accept, ring walk and final result
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= ST_IDLE;
      cnt        <= '0;
      nres       <= '0;
      done       <= 1'b0;
      start_ok   <= 1'b0;
      pend_valid <= 1'b0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            state      <= ST_SCAN;
            cnt        <= '0;
            nres       <= '0;
            done       <= (in_data.cmd == CMD_START) && (in_data.key_id == '0);
            start_ok   <= 1'b0;
            pend_valid <= 1'b0;
          end
        end
        ST_SCAN: begin
          if (advance) begin
            cnt <= cnt + CNT_W'(1);
            if (res.fin) begin
              done     <= 1'b1;
              start_ok <= res.ok;
            end
            if (res.hit) begin
              pend_valid <= 1'b1;
              nres       <= nres + NRES_W'(1);
            end
            if (scan_end) begin
              state <= ST_DONE;
            end
          end
        end
        ST_DONE: begin
          if (out_free) begin
            state      <= ST_IDLE;
            pend_valid <= 1'b0;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  // Item and pending-repeat payload
  always_ff @(posedge clk) begin
    if (state == ST_IDLE && in_valid) begin
      cur <= in_data;
    end
    if (advance && res.hit) begin
      pend_key <= res.slot.key;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_data <= emit_data;
    end
  end

  `KAS_ASSERT_NOW(a_nres_bound, 1'b1, nres <= NRES_W'(MAX_RESULTS))
  `KAS_ASSERT_NOW(a_pend_tick_only, pend_valid, cur.cmd == CMD_TICK)
  `KAS_ASSERT_NEXT(a_accept_starts_walk, in_valid && !in_stall,
                   state == ST_SCAN && cnt == '0)
  `KAS_ASSERT_NEXT(a_walk_ends, advance && scan_end, state == ST_DONE)

endmodule

// ----- sv/kas_cell.sv -----
`timescale 1ns / 1ps
module kas_cell (
  input  logic           clk,
  input  logic           rst,
  input  logic           shift,
  input  kas_pkg::slot_t slot_in,
  output kas_pkg::slot_t slot_out
);
  import kas_pkg::*;

  slot_t slot;

  // Take the neighbor's slot on each shift; reset frees the slot
  always_ff @(posedge clk) begin
    if (rst) begin
      slot.active <= 1'b0;
    end else if (shift) begin
      slot <= slot_in;
    end
  end

  assign slot_out = slot;

endmodule

// ----- sv/kas_head.sv -----
`timescale 1ns / 1ps
module kas_head (
  input  kas_pkg::slot_t              head,
  input  kas_pkg::cmd_t               cmd,
  input  logic [kas_pkg::KEY_W-1:0]   key,
  input  logic [kas_pkg::TIME_W-1:0]  now,
  input  logic [kas_pkg::DELAY_W-1:0] delay,
  input  logic [kas_pkg::DELAY_W-1:0] interval,
  input  logic                        done,
  input  logic                        room,
  output kas_pkg::head_res_t          res
);
  import kas_pkg::*;

  logic key_hit;

  assign key_hit = head.active && (head.key == key);

  // Decide what happens to the slot at the head of the ring
  always_comb begin
    res      = '0;
    res.slot = head;
    unique case (cmd)
      CMD_START: begin
        if (!done) begin
          if (key_hit) begin
            res.fin = 1'b1;
          end else if (!head.active) begin
            res.fin         = 1'b1;
            res.ok          = 1'b1;
            res.slot.active = 1'b1;
            res.slot.key    = key;
            res.slot.due    = add_sat(now, delay);
          end
        end
      end
      CMD_STOP: begin
        if (key_hit) begin
          res.slot.active = 1'b0;
        end
      end
      CMD_TICK: begin
        if (head.active && (now >= head.due) && room) begin
          res.hit      = 1'b1;
          res.slot.due = add_sat(now, interval);
        end
      end
      default: begin
        res.slot = head;
      end
    endcase
  end

endmodule
